// ===== hw/rtl/buc_pkg.sv =====
package buc_pkg;

  localparam int CODE_BITS  = 12323;
  localparam int CODE_WORDS = 193;
  localparam int PLANES     = 8;

  localparam int WORD_W = 64;
  localparam int IDX_W  = 8;
  localparam int AMT_W  = 14;
  localparam int FILL_W = 7;
  localparam int ROW_W  = PLANES * WORD_W;

  // Number of live positions in the last syndrome word.
  localparam int LAST_BITS = CODE_BITS - WORD_W * (CODE_WORDS - 1);

  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(CODE_WORDS - 1);
  localparam logic [FILL_W-1:0] LAST_LEN  = FILL_W'(LAST_BITS);
  localparam logic [FILL_W-1:0] FULL_LEN  = FILL_W'(WORD_W);
  localparam logic [AMT_W-1:0]  CODE_LEN  = AMT_W'(CODE_BITS);

  localparam logic [2:0] OP_LOAD  = 3'd0;
  localparam logic [2:0] OP_CLEAR = 3'd1;
  localparam logic [2:0] OP_ROTACC = 3'd2;
  localparam logic [2:0] OP_SUB   = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  typedef struct packed {
    logic latch;
    logic row_clr;
    logic row_inc;
    logic rot_init;
    logic syn_rd;
    logic syn_wr_load;
    logic syn_wr_zero;
    logic cnt_rd_row;
    logic cnt_rd_widx;
    logic cnt_wr_zero;
    logic rot_append;
    logic acc_wr;
    logic sub_wr;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       idx_ok;
    logic       row_last;
    logic       fill_ok;
    logic       out_free;
  } stat_t;

  function automatic logic [FILL_W-1:0] word_len(input logic [IDX_W-1:0] idx);
    return (idx == LAST_IDX) ? LAST_LEN : FULL_LEN;
  endfunction

  function automatic logic [WORD_W-1:0] word_mask(input logic [IDX_W-1:0] idx);
    logic [WORD_W-1:0] m;
    m = (WORD_W'(1) << LAST_LEN) - WORD_W'(1);
    return (idx == LAST_IDX) ? m : {WORD_W{1'b1}};
  endfunction

endpackage

// ===== hw/rtl/buc_ctrl.sv =====
module buc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  buc_pkg::stat_t stat,
  output buc_pkg::cmd_t  cmd
);
  import buc_pkg::*;

  localparam logic [3:0] S_INIT    = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_DEC     = 4'd2;
  localparam logic [3:0] S_CLR     = 4'd3;
  localparam logic [3:0] S_ROT_RD  = 4'd4;
  localparam logic [3:0] S_ROT_APP = 4'd5;
  localparam logic [3:0] S_ACC_RD  = 4'd6;
  localparam logic [3:0] S_ACC_WR  = 4'd7;
  localparam logic [3:0] S_SUB_RD  = 4'd8;
  localparam logic [3:0] S_SUB_WR  = 4'd9;
  localparam logic [3:0] S_FIN     = 4'd10;

  logic [3:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_INIT: begin
        cmd.syn_wr_zero = 1'b1;
        cmd.cnt_wr_zero = 1'b1;
        cmd.row_inc     = 1'b1;
        if (stat.row_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.row_clr = 1'b1;
        state_nxt   = S_FIN;
        case (stat.op)
          OP_LOAD:   cmd.syn_wr_load = stat.idx_ok;
          OP_CLEAR:  state_nxt = S_CLR;
          OP_ROTACC: begin
            cmd.rot_init = 1'b1;
            state_nxt    = S_ROT_RD;
          end
          OP_SUB:    state_nxt = S_SUB_RD;
          OP_READ:   cmd.cnt_rd_widx = stat.idx_ok;
          default:   state_nxt = S_FIN;
        endcase
      end
      S_CLR: begin
        cmd.cnt_wr_zero = 1'b1;
        cmd.row_inc     = 1'b1;
        if (stat.row_last) begin
          state_nxt = S_FIN;
        end
      end
      S_ROT_RD: begin
        // Enough rotated bits gathered for the current word: go update it.
        if (stat.fill_ok) begin
          cmd.cnt_rd_row = 1'b1;
          state_nxt      = S_ACC_RD;
        end else begin
          cmd.syn_rd = 1'b1;
          state_nxt  = S_ROT_APP;
        end
      end
      S_ROT_APP: begin
        cmd.rot_append = 1'b1;
        state_nxt      = S_ROT_RD;
      end
      S_ACC_RD: begin
        state_nxt = S_ACC_WR;
      end
      S_ACC_WR: begin
        cmd.acc_wr  = 1'b1;
        cmd.row_inc = 1'b1;
        state_nxt   = stat.row_last ? S_FIN : S_ROT_RD;
      end
      S_SUB_RD: begin
        cmd.cnt_rd_row = 1'b1;
        state_nxt      = S_SUB_WR;
      end
      S_SUB_WR: begin
        cmd.sub_wr  = 1'b1;
        cmd.row_inc = 1'b1;
        state_nxt   = stat.row_last ? S_FIN : S_SUB_RD;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

endmodule

// ===== hw/rtl/buc_datapath.sv =====
module buc_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  buc_pkg::cmd_t                cmd,
  output buc_pkg::stat_t               stat,
  input  logic [2:0]                   in_opcode,
  input  logic [buc_pkg::IDX_W-1:0]    in_word_index,
  input  logic [buc_pkg::WORD_W-1:0]   in_word_data,
  input  logic [buc_pkg::AMT_W-1:0]    in_rotate_amount,
  input  logic [3:0]                   in_slices_used,
  input  logic [7:0]                   in_sub_value,
  input  logic [2:0]                   in_plane_select,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [buc_pkg::WORD_W-1:0]   out_read_data,
  output logic                         out_op_done
);
  import buc_pkg::*;

  logic [WORD_W-1:0] syn_mem [CODE_WORDS];
  logic [ROW_W-1:0]  cnt_mem [CODE_WORDS];

  logic [2:0]          op_r;
  logic [IDX_W-1:0]    widx_r;
  logic [WORD_W-1:0]   data_r;
  logic [AMT_W-1:0]    amt_r;
  logic [3:0]          slices_r;
  logic [7:0]          subv_r;
  logic [2:0]          plane_r;

  logic [IDX_W-1:0]    row_r;
  logic [IDX_W-1:0]    sw_r;
  logic [5:0]          off_r;
  logic [2*WORD_W-1:0] acc_r;
  logic [FILL_W-1:0]   fill_r;
  logic [WORD_W-1:0]   syn_q_r;
  logic [ROW_W-1:0]    cnt_q_r;

  logic                out_valid_r;
  logic [WORD_W-1:0]   out_data_r;
  logic                out_done_r;

  logic                idx_ok;
  logic                plane_ok;
  logic [FILL_W-1:0]   app_cnt;
  logic [WORD_W-1:0]   app_bits;
  logic [WORD_W-1:0]   rot_word;
  logic [ROW_W-1:0]    acc_row;
  logic [ROW_W-1:0]    sub_row;
  logic [WORD_W-1:0]   carry;
  logic [WORD_W-1:0]   plane_w;
  logic [PLANES-1:0]   pos_val;
  logic [PLANES-1:0]   pos_dif;
  logic [WORD_W-1:0]   row_mask;
  logic [3:0]          slices_sat;
  logic [WORD_W-1:0]   res_data;
  logic                res_done;

  assign idx_ok   = (widx_r < IDX_W'(CODE_WORDS));
  assign plane_ok = ({1'b0, plane_r} < 4'(PLANES));
  assign row_mask = word_mask(row_r);

  assign stat.op       = op_r;
  assign stat.idx_ok   = idx_ok;
  assign stat.row_last = (row_r == LAST_IDX);
  assign stat.fill_ok  = (fill_r >= word_len(row_r));
  assign stat.out_free = !out_valid_r || !out_stall;

  // Input beat capture; the rotation is reduced once here.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r     <= in_opcode;
      widx_r   <= in_word_index;
      data_r   <= in_word_data;
      amt_r    <= (in_rotate_amount >= CODE_LEN) ? (in_rotate_amount - CODE_LEN)
                                                 : in_rotate_amount;
      slices_r <= in_slices_used;
      subv_r   <= in_sub_value;
      plane_r  <= in_plane_select;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else if (cmd.row_clr) begin
      row_r <= '0;
    end else if (cmd.row_inc) begin
      row_r <= stat.row_last ? '0 : row_r + IDX_W'(1);
    end
  end

  // Gathering of rotated bits: the source cursor walks the syndrome cyclically.
  assign app_cnt  = word_len(sw_r) - {1'b0, off_r};
  assign app_bits = syn_q_r >> off_r;

  always_ff @(posedge clk) begin
    if (cmd.rot_init) begin
      sw_r   <= amt_r[AMT_W-1:6];
      off_r  <= amt_r[5:0];
      acc_r  <= '0;
      fill_r <= '0;
    end else if (cmd.rot_append) begin
      sw_r   <= (sw_r == LAST_IDX) ? '0 : sw_r + IDX_W'(1);
      off_r  <= '0;
      acc_r  <= acc_r | ({{WORD_W{1'b0}}, app_bits} << fill_r);
      fill_r <= fill_r + app_cnt;
    end else if (cmd.acc_wr) begin
      acc_r  <= acc_r >> WORD_W;
      fill_r <= fill_r - FULL_LEN;
    end
  end

  assign rot_word   = acc_r[WORD_W-1:0] & row_mask;
  assign slices_sat = (slices_r > 4'(PLANES)) ? 4'(PLANES) : slices_r;

  // Half-adder ripple through the used planes.
  always_comb begin
    carry = rot_word;
    for (int j = 0; j < PLANES; j++) begin
      plane_w = cnt_q_r[j*WORD_W +: WORD_W];
      if (4'(j) < slices_sat) begin
        acc_row[j*WORD_W +: WORD_W] = plane_w ^ carry;
        carry = plane_w & carry;
      end else begin
        acc_row[j*WORD_W +: WORD_W] = plane_w;
      end
    end
  end

  // Each position's counter is gathered from the planes and reduced on its own.
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      for (int j = 0; j < PLANES; j++) begin
        pos_val[j] = cnt_q_r[j*WORD_W + b];
      end
      pos_dif = pos_val - subv_r[PLANES-1:0];
      for (int j = 0; j < PLANES; j++) begin
        sub_row[j*WORD_W + b] = pos_dif[j] & row_mask[b];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.syn_wr_zero) begin
      syn_mem[row_r] <= '0;
    end else if (cmd.syn_wr_load) begin
      syn_mem[widx_r] <= data_r & word_mask(widx_r);
    end
    if (cmd.syn_rd) begin
      syn_q_r <= syn_mem[sw_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cnt_wr_zero) begin
      cnt_mem[row_r] <= '0;
    end else if (cmd.acc_wr) begin
      cnt_mem[row_r] <= acc_row;
    end else if (cmd.sub_wr) begin
      cnt_mem[row_r] <= sub_row;
    end
    if (cmd.cnt_rd_row) begin
      cnt_q_r <= cnt_mem[row_r];
    end else if (cmd.cnt_rd_widx) begin
      cnt_q_r <= cnt_mem[widx_r];
    end
  end

  always_comb begin
    res_data = '0;
    res_done = 1'b0;
    case (op_r)
      OP_LOAD:   res_done = idx_ok;
      OP_CLEAR:  res_done = 1'b1;
      OP_ROTACC: res_done = 1'b1;
      OP_SUB:    res_done = 1'b1;
      OP_READ: begin
        res_done = idx_ok && plane_ok;
        if (res_done) begin
          res_data = cnt_q_r[plane_r*WORD_W +: WORD_W];
        end
      end
      default:   res_done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_data_r <= res_data;
      out_done_r <= res_done;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;
  assign out_op_done   = out_done_r;

endmodule

// ===== hw/rtl/bit_sliced_upc_counters.sv =====
// Bit-sliced counter block for a cyclic syndrome of 12323 bits in 193 words,
// with eight counter planes stored as one 512-bit row per word position.
// Input channel: in_valid / in_stall with one port per field; output channel:
// out_valid / out_stall carrying out_read_data and out_op_done. Every input
// beat gives exactly one output beat, in order.
// Work per beat, set by the single-port row sweeps of the two memories:
//   load, read, unknown opcode or bad index: a single decode step, no sweep.
//   clear counters: one row per cycle.
//   subtract: read and write each row.
//   rotate-accumulate: one syndrome read per source word, then a
//   read-modify-write of the row.
// In_stall is high whenever an operation is under way; one beat is worked at
// a time. The result sits in an output register, so a new beat is taken while
// it waits; the next result waits in turn until the previous one is taken.
// After reset both memories are cleared by a pass over all 193 rows, during which
// in_stall stays high. A stalled output holds its beat unchanged.
module bit_sliced_upc_counters (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 in_opcode,
  input  logic [buc_pkg::IDX_W-1:0]  in_word_index,
  input  logic [buc_pkg::WORD_W-1:0] in_word_data,
  input  logic [buc_pkg::AMT_W-1:0]  in_rotate_amount,
  input  logic [3:0]                 in_slices_used,
  input  logic [7:0]                 in_sub_value,
  input  logic [2:0]                 in_plane_select,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [buc_pkg::WORD_W-1:0] out_read_data,
  output logic                       out_op_done
);
  import buc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  buc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  buc_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_opcode        (in_opcode),
    .in_word_index    (in_word_index),
    .in_word_data     (in_word_data),
    .in_rotate_amount (in_rotate_amount),
    .in_slices_used   (in_slices_used),
    .in_sub_value     (in_sub_value),
    .in_plane_select  (in_plane_select),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_op_done      (out_op_done)
  );

  // An accepted beat always keeps the input side busy for the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted on consecutive cycles");

  // The block is busy clearing its memories straight after reset.
  a_busy_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input ready during reset clearing pass");

  // Non-zero data only ever comes from a successful read.
  a_data_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_read_data != '0) |-> out_op_done)
    else $error("read data without completed operation");

  // A new result is loaded only once the previous one has been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> !out_valid || !out_stall)
    else $error("result register overwritten while stalled");

endmodule
